>>> rtl/core/scar_pkg.sv
// Shared constants, types and coefficient functions for the stereo reverb.
package scar_pkg;

   // Delay line lengths
   localparam int COMB_LEN_A    = 1116;
   localparam int COMB_LEN_B    = 1188;
   localparam int COMB_LEN_C    = 1277;
   localparam int COMB_LEN_D    = 1356;
   localparam int ALLPASS_LEN_A = 225;
   localparam int ALLPASS_LEN_B = 556;

   localparam int COMB_DEPTH = COMB_LEN_A + COMB_LEN_B + COMB_LEN_C + COMB_LEN_D;
   localparam int AP_DEPTH   = ALLPASS_LEN_A + ALLPASS_LEN_B;
   localparam int COMB_AW    = $clog2(COMB_DEPTH);
   localparam int AP_AW      = $clog2(AP_DEPTH);
   localparam int COMB_PW    = 11;
   localparam int AP_PW      = 10;

   // Data widths
   localparam int SAMPLE_W = 24;
   localparam int COMB_W   = 30;
   localparam int AP_W     = 26;
   localparam int AMT_W    = 11;
   localparam int FB_W     = 16;
   localparam int SUM_W    = 32;
   localparam int M1_W     = 33;
   localparam int M2_W     = 18;
   localparam int PROD_W   = M1_W + M2_W;
   localparam int MAC_W    = 52;

   // Coefficients: amount is Q1.10, feedback is Q0.16
   localparam int AMT_ONE  = 1024;
   localparam int FB_BASE  = 49152;
   localparam int FB_SLOPE = 14418;

   // Configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic [CSR_AW-3:0] REG_AMOUNT = '0;

   // Rounding/shift/clamp modes of the shared arithmetic unit
   typedef enum logic [2:0] {
      MODE_RAW,
      MODE_COMB,
      MODE_AVG,
      MODE_AP,
      MODE_MIX
   } mac_mode_type;

   // One operation for the shared unit: m1 * m2 + addend, then mode
   typedef struct packed {
      logic                     valid;
      mac_mode_type             mode;
      logic signed [M1_W-1:0]   m1;
      logic signed [M2_W-1:0]   m2;
      logic signed [MAC_W-1:0]  addend;
   } mac_op_type;

   // Delay store control
   typedef struct packed {
      logic [COMB_AW-1:0] comb_addr;
      logic               comb_re;
      logic               comb_we_l;
      logic               comb_we_r;
      logic [AP_AW-1:0]   ap_addr;
      logic               ap_re;
      logic               ap_we_l;
      logic               ap_we_r;
   } store_ctl_type;

   function automatic logic [COMB_PW-1:0] comb_len(input logic [1:0] c);
      logic [COMB_PW-1:0] len;
      case (c)
         2'd0:    len = COMB_PW'(COMB_LEN_A);
         2'd1:    len = COMB_PW'(COMB_LEN_B);
         2'd2:    len = COMB_PW'(COMB_LEN_C);
         default: len = COMB_PW'(COMB_LEN_D);
      endcase
      return len;
   endfunction

   function automatic logic [COMB_AW-1:0] comb_base(input logic [1:0] c);
      logic [COMB_AW-1:0] base;
      case (c)
         2'd0:    base = '0;
         2'd1:    base = COMB_AW'(COMB_LEN_A);
         2'd2:    base = COMB_AW'(COMB_LEN_A + COMB_LEN_B);
         default: base = COMB_AW'(COMB_LEN_A + COMB_LEN_B + COMB_LEN_C);
      endcase
      return base;
   endfunction

   function automatic logic [AP_PW-1:0] ap_len(input logic k);
      return k ? AP_PW'(ALLPASS_LEN_B) : AP_PW'(ALLPASS_LEN_A);
   endfunction

   function automatic logic [AP_AW-1:0] ap_base(input logic k);
      return k ? AP_AW'(ALLPASS_LEN_A) : '0;
   endfunction

   // 0.75 + 0.22 * amount, rounded, Q0.16
   function automatic logic [FB_W-1:0] fb_coef(input logic [AMT_W-1:0] a);
      logic [24:0] t;
      t = 25'(FB_SLOPE) * 25'(a) + 25'd512;
      return FB_W'(FB_BASE + int'(t >> 10));
   endfunction

endpackage

>>> rtl/core/scar_req_if.sv
// Request channel: one dry stereo pair.
interface scar_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [scar_pkg::SAMPLE_W-1:0]  left_in;
   logic signed [scar_pkg::SAMPLE_W-1:0]  right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

>>> rtl/core/scar_rsp_if.sv
// Response channel: one mixed stereo pair.
interface scar_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [scar_pkg::SAMPLE_W-1:0]  left_out;
   logic signed [scar_pkg::SAMPLE_W-1:0]  right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

>>> rtl/core/stereo_comb_allpass_reverb.sv
// Stereo comb and allpass reverb top level: register port, coefficients and unit wiring.
//
// Each request carries one stereo pair and yields one mixed pair. The one
// shared multiply-add unit steps through four comb lines, the average, two
// allpass stages and the two-term mix for each channel in turn, each delay
// line costing one memory read and two writes. The request side is not ready
// while a pair is in work; the finished pair sits in an output register, so
// the next request is taken even when the previous result has not yet been
// collected. The delay memories need no clearing pass: a line that has not yet
// wrapped since reset reads as silence. The amount register sits at byte
// address 0 and values above 1024 act as 1024.
module stereo_comb_allpass_reverb (
   input  logic                                clock,
   input  logic                                reset,
   scar_req_if.sink                            req_chan,
   scar_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [scar_pkg::CSR_AW-1:0]         csr_paddr,
   input  logic [scar_pkg::CSR_DW-1:0]         csr_pwdata,
   output logic [scar_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                                csr_pready
);

   logic [scar_pkg::AMT_W-1:0]            amount_ff, amount_in;
   logic [scar_pkg::AMT_W-1:0]            amt_clamp_ff, amt_clamp_in;
   logic [scar_pkg::FB_W-1:0]             fb_ff;
   logic                                  csr_hit;

   scar_pkg::mac_op_type                  mac_op;
   logic signed [scar_pkg::MAC_W-1:0]     mac_result;
   scar_pkg::store_ctl_type               store_ctl;
   logic signed [scar_pkg::COMB_W-1:0]    comb_wdata, comb_rd_l, comb_rd_r;
   logic signed [scar_pkg::AP_W-1:0]      ap_wdata, ap_rd_l, ap_rd_r;

   // Register decode
   assign csr_hit    = (csr_paddr[scar_pkg::CSR_AW-1:2] == scar_pkg::REG_AMOUNT);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? scar_pkg::CSR_DW'(amount_ff) : '0;

   always_comb begin
      amount_in = amount_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         amount_in = csr_pwdata[scar_pkg::AMT_W-1:0];
      end
      amt_clamp_in = (amount_ff > scar_pkg::AMT_W'(scar_pkg::AMT_ONE)) ?
                     scar_pkg::AMT_W'(scar_pkg::AMT_ONE) : amount_ff;
   end

   // Amount register, then clamped amount and feedback coefficient
   always_ff @(posedge clock) begin
      if (reset) begin
         amount_ff <= '0;
      end else begin
         amount_ff <= amount_in;
      end
      amt_clamp_ff <= amt_clamp_in;
      fb_ff        <= scar_pkg::fb_coef(amt_clamp_ff);
   end

   scar_store u_store (
      .clock      (clock),
      .ctl        (store_ctl),
      .comb_wdata (comb_wdata),
      .ap_wdata   (ap_wdata),
      .comb_rd_l  (comb_rd_l),
      .comb_rd_r  (comb_rd_r),
      .ap_rd_l    (ap_rd_l),
      .ap_rd_r    (ap_rd_r)
   );

   scar_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .op     (mac_op),
      .result (mac_result)
   );

   scar_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .amount     (amt_clamp_ff),
      .fb         (fb_ff),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .mac_op     (mac_op),
      .mac_result (mac_result),
      .store_ctl  (store_ctl),
      .comb_wdata (comb_wdata),
      .ap_wdata   (ap_wdata),
      .comb_rd_l  (comb_rd_l),
      .comb_rd_r  (comb_rd_r),
      .ap_rd_l    (ap_rd_l),
      .ap_rd_r    (ap_rd_r)
   );

endmodule

>>> rtl/core/scar_store.sv
// Comb and allpass delay memories for both channels, registered reads.
module scar_store (
   input  logic                                 clock,
   input  scar_pkg::store_ctl_type              ctl,
   input  logic signed [scar_pkg::COMB_W-1:0]   comb_wdata,
   input  logic signed [scar_pkg::AP_W-1:0]     ap_wdata,
   output logic signed [scar_pkg::COMB_W-1:0]   comb_rd_l,
   output logic signed [scar_pkg::COMB_W-1:0]   comb_rd_r,
   output logic signed [scar_pkg::AP_W-1:0]     ap_rd_l,
   output logic signed [scar_pkg::AP_W-1:0]     ap_rd_r
);

   logic signed [scar_pkg::COMB_W-1:0] comb_mem_l [scar_pkg::COMB_DEPTH];
   logic signed [scar_pkg::COMB_W-1:0] comb_mem_r [scar_pkg::COMB_DEPTH];
   logic signed [scar_pkg::AP_W-1:0]   ap_mem_l   [scar_pkg::AP_DEPTH];
   logic signed [scar_pkg::AP_W-1:0]   ap_mem_r   [scar_pkg::AP_DEPTH];

   // Comb lines, all four packed back to back
   always_ff @(posedge clock) begin
      if (ctl.comb_we_l) begin
         comb_mem_l[ctl.comb_addr] <= comb_wdata;
      end
      if (ctl.comb_we_r) begin
         comb_mem_r[ctl.comb_addr] <= comb_wdata;
      end
      if (ctl.comb_re) begin
         comb_rd_l <= comb_mem_l[ctl.comb_addr];
         comb_rd_r <= comb_mem_r[ctl.comb_addr];
      end
   end

   // Allpass lines
   always_ff @(posedge clock) begin
      if (ctl.ap_we_l) begin
         ap_mem_l[ctl.ap_addr] <= ap_wdata;
      end
      if (ctl.ap_we_r) begin
         ap_mem_r[ctl.ap_addr] <= ap_wdata;
      end
      if (ctl.ap_re) begin
         ap_rd_l <= ap_mem_l[ctl.ap_addr];
         ap_rd_r <= ap_mem_r[ctl.ap_addr];
      end
   end

endmodule

>>> rtl/core/scar_mac.sv
// Shared multiply-add unit with floor shift and saturation, product and result registered.
module scar_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  scar_pkg::mac_op_type                op,
   output logic signed [scar_pkg::MAC_W-1:0]   result
);

   localparam logic signed [scar_pkg::MAC_W-1:0] HI_COMB =
      {{(scar_pkg::MAC_W-scar_pkg::COMB_W+1){1'b0}}, {(scar_pkg::COMB_W-1){1'b1}}};
   localparam logic signed [scar_pkg::MAC_W-1:0] HI_AP =
      {{(scar_pkg::MAC_W-scar_pkg::AP_W+1){1'b0}}, {(scar_pkg::AP_W-1){1'b1}}};
   localparam logic signed [scar_pkg::MAC_W-1:0] HI_OUT =
      {{(scar_pkg::MAC_W-scar_pkg::SAMPLE_W+1){1'b0}}, {(scar_pkg::SAMPLE_W-1){1'b1}}};
   localparam logic signed [scar_pkg::MAC_W-1:0] HI_RAW =
      {1'b0, {(scar_pkg::MAC_W-1){1'b1}}};

   logic                                 valid1_ff;
   scar_pkg::mac_mode_type               mode_ff;
   logic signed [scar_pkg::PROD_W-1:0]   prod_in;
   logic signed [scar_pkg::MAC_W-1:0]    prod_ff;
   logic signed [scar_pkg::MAC_W-1:0]    addend_ff;
   logic signed [scar_pkg::MAC_W-1:0]    result_in;
   logic signed [scar_pkg::MAC_W-1:0]    result_ff;
   logic signed [scar_pkg::MAC_W-1:0]    sum;
   logic signed [scar_pkg::MAC_W-1:0]    shifted;
   logic signed [scar_pkg::MAC_W-1:0]    hi;

   assign prod_in = op.m1 * op.m2;

   // Stage 1: product
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= op.valid;
      end
      if (op.valid) begin
         prod_ff   <= scar_pkg::MAC_W'(prod_in);
         addend_ff <= op.addend;
         mode_ff   <= op.mode;
      end
   end

   // Stage 2: add, floor shift, clamp
   always_comb begin
      sum = prod_ff + addend_ff;
      case (mode_ff)
         scar_pkg::MODE_COMB: begin
            shifted = sum >>> 16;
            hi      = HI_COMB;
         end
         scar_pkg::MODE_AVG: begin
            shifted = sum >>> 2;
            hi      = HI_AP;
         end
         scar_pkg::MODE_AP: begin
            shifted = sum >>> 1;
            hi      = HI_AP;
         end
         scar_pkg::MODE_MIX: begin
            shifted = sum >>> 10;
            hi      = HI_OUT;
         end
         default: begin
            shifted = sum;
            hi      = HI_RAW;
         end
      endcase
      if (shifted > hi) begin
         result_in = hi;
      end else if (shifted < ~hi) begin
         result_in = ~hi;
      end else begin
         result_in = shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (valid1_ff) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> rtl/core/scar_seq.sv
// Sequencer: walks the comb, average, allpass and mix steps through the shared unit.
module scar_seq (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [scar_pkg::AMT_W-1:0]            amount,
   input  logic [scar_pkg::FB_W-1:0]             fb,
   scar_req_if.sink                              req_chan,
   scar_rsp_if.source                            rsp_chan,
   output scar_pkg::mac_op_type                  mac_op,
   input  logic signed [scar_pkg::MAC_W-1:0]     mac_result,
   output scar_pkg::store_ctl_type               store_ctl,
   output logic signed [scar_pkg::COMB_W-1:0]    comb_wdata,
   output logic signed [scar_pkg::AP_W-1:0]      ap_wdata,
   input  logic signed [scar_pkg::COMB_W-1:0]    comb_rd_l,
   input  logic signed [scar_pkg::COMB_W-1:0]    comb_rd_r,
   input  logic signed [scar_pkg::AP_W-1:0]      ap_rd_l,
   input  logic signed [scar_pkg::AP_W-1:0]      ap_rd_r
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_C_READ, ST_C_OPL, ST_C_OPR, ST_C_WRL, ST_C_WRR,
      ST_AVG_L, ST_AVG_R, ST_AVG_GL, ST_AVG_GR,
      ST_A_READ, ST_A_VL, ST_A_VR, ST_A_WL, ST_A_WR,
      ST_A_OL, ST_A_OR, ST_A_XL, ST_A_XR,
      ST_MIX_L1, ST_MIX_R1, ST_MIX_L2, ST_MIX_R2, ST_MIX_GL, ST_MIX_GR,
      ST_DONE
   } state_type;

   state_type                               state_ff, state_in;
   logic [1:0]                              c_ff, c_in;
   logic                                    k_ff, k_in;
   logic [scar_pkg::COMB_PW-1:0]            comb_pos_ff [4];
   logic [scar_pkg::COMB_PW-1:0]            comb_pos_in [4];
   logic [3:0]                              comb_full_ff, comb_full_in;
   logic [scar_pkg::AP_PW-1:0]              ap_pos_ff [2];
   logic [scar_pkg::AP_PW-1:0]              ap_pos_in [2];
   logic [1:0]                              ap_full_ff, ap_full_in;
   logic                                    armed_ff, armed_in;
   logic                                    out_valid_ff, out_valid_in;

   logic signed [scar_pkg::SAMPLE_W-1:0]    dl_ff, dl_in, dr_ff, dr_in;
   logic signed [scar_pkg::SUM_W-1:0]       suml_ff, suml_in, sumr_ff, sumr_in;
   logic signed [scar_pkg::AP_W-1:0]        bl_ff, bl_in, br_ff, br_in;
   logic signed [scar_pkg::AP_W-1:0]        vl_ff, vl_in, vr_ff, vr_in;
   logic signed [scar_pkg::AP_W-1:0]        xl_ff, xl_in, xr_ff, xr_in;
   logic signed [scar_pkg::SAMPLE_W-1:0]    wl_ff, wl_in, wr_ff, wr_in;
   logic signed [scar_pkg::SAMPLE_W-1:0]    out_l_ff, out_l_in, out_r_ff, out_r_in;

   logic signed [scar_pkg::COMB_W-1:0]      yl, yr;
   logic signed [scar_pkg::AP_W-1:0]        bl_rd, br_rd;
   logic [scar_pkg::FB_W-1:0]               fb_eff;
   logic [scar_pkg::COMB_PW-1:0]            comb_next;
   logic [scar_pkg::AP_PW-1:0]              ap_next;
   logic                                    out_free;

   // Entries of a line that has not yet wrapped were never written and read as zero
   assign yl     = comb_full_ff[c_ff] ? comb_rd_l : '0;
   assign yr     = comb_full_ff[c_ff] ? comb_rd_r : '0;
   assign bl_rd  = ap_full_ff[k_ff] ? ap_rd_l : '0;
   assign br_rd  = ap_full_ff[k_ff] ? ap_rd_r : '0;
   assign fb_eff = armed_ff ? fb : '0;

   assign comb_next = comb_pos_ff[c_ff] + scar_pkg::COMB_PW'(1);
   assign ap_next   = ap_pos_ff[k_ff] + scar_pkg::AP_PW'(1);
   assign out_free  = !out_valid_ff || rsp_chan.ready;

   // Store addressing: current position of the line in work
   always_comb begin
      store_ctl           = '0;
      store_ctl.comb_addr = scar_pkg::comb_base(c_ff) +
                            scar_pkg::COMB_AW'(comb_pos_ff[c_ff]);
      store_ctl.ap_addr   = scar_pkg::ap_base(k_ff) + scar_pkg::AP_AW'(ap_pos_ff[k_ff]);
      store_ctl.comb_re   = (state_ff == ST_C_READ);
      store_ctl.comb_we_l = (state_ff == ST_C_WRL);
      store_ctl.comb_we_r = (state_ff == ST_C_WRR);
      store_ctl.ap_re     = (state_ff == ST_A_READ);
      store_ctl.ap_we_l   = (state_ff == ST_A_WL);
      store_ctl.ap_we_r   = (state_ff == ST_A_WR);
   end

   assign comb_wdata = mac_result[scar_pkg::COMB_W-1:0];
   assign ap_wdata   = mac_result[scar_pkg::AP_W-1:0];

   // Next state and datapath
   always_comb begin
      state_in     = state_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      comb_pos_in  = comb_pos_ff;
      comb_full_in = comb_full_ff;
      ap_pos_in    = ap_pos_ff;
      ap_full_in   = ap_full_ff;
      armed_in     = armed_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      dl_in        = dl_ff;
      dr_in        = dr_ff;
      suml_in      = suml_ff;
      sumr_in      = sumr_ff;
      bl_in        = bl_ff;
      br_in        = br_ff;
      vl_in        = vl_ff;
      vr_in        = vr_ff;
      xl_in        = xl_ff;
      xr_in        = xr_ff;
      wl_in        = wl_ff;
      wr_in        = wr_ff;
      out_l_in     = out_l_ff;
      out_r_in     = out_r_ff;
      mac_op       = '0;
      mac_op.mode  = scar_pkg::MODE_RAW;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               dl_in    = req_chan.left_in;
               dr_in    = req_chan.right_in;
               suml_in  = '0;
               sumr_in  = '0;
               c_in     = '0;
               state_in = ST_C_READ;
            end
         end
         ST_C_READ: begin
            state_in = ST_C_OPL;
         end
         // Comb: dry + round(fb * y), saturated to the store width
         ST_C_OPL: begin
            mac_op.valid  = 1'b1;
            mac_op.mode   = scar_pkg::MODE_COMB;
            mac_op.m1     = scar_pkg::M1_W'(yl);
            mac_op.m2     = signed'(scar_pkg::M2_W'(fb_eff));
            mac_op.addend = (scar_pkg::MAC_W'(dl_ff) <<< 16) + scar_pkg::MAC_W'(32768);
            suml_in       = suml_ff + scar_pkg::SUM_W'(yl);
            state_in      = ST_C_OPR;
         end
         ST_C_OPR: begin
            mac_op.valid  = 1'b1;
            mac_op.mode   = scar_pkg::MODE_COMB;
            mac_op.m1     = scar_pkg::M1_W'(yr);
            mac_op.m2     = signed'(scar_pkg::M2_W'(fb_eff));
            mac_op.addend = (scar_pkg::MAC_W'(dr_ff) <<< 16) + scar_pkg::MAC_W'(32768);
            sumr_in       = sumr_ff + scar_pkg::SUM_W'(yr);
            state_in      = ST_C_WRL;
         end
         ST_C_WRL: begin
            state_in = ST_C_WRR;
         end
         ST_C_WRR: begin
            if (comb_next == scar_pkg::comb_len(c_ff)) begin
               comb_pos_in[c_ff]  = '0;
               comb_full_in[c_ff] = 1'b1;
            end else begin
               comb_pos_in[c_ff] = comb_next;
            end
            if (c_ff == 2'd3) begin
               armed_in = 1'b1;
               c_in     = '0;
               state_in = ST_AVG_L;
            end else begin
               c_in     = c_ff + 2'd1;
               state_in = ST_C_READ;
            end
         end
         // Average of the four comb taps, rounded
         ST_AVG_L: begin
            mac_op.valid  = 1'b1;
            mac_op.mode   = scar_pkg::MODE_AVG;
            mac_op.m1     = scar_pkg::M1_W'(suml_ff);
            mac_op.m2     = scar_pkg::M2_W'(1);
            mac_op.addend = scar_pkg::MAC_W'(2);
            state_in      = ST_AVG_R;
         end
         ST_AVG_R: begin
            mac_op.valid  = 1'b1;
            mac_op.mode   = scar_pkg::MODE_AVG;
            mac_op.m1     = scar_pkg::M1_W'(sumr_ff);
            mac_op.m2     = scar_pkg::M2_W'(1);
            mac_op.addend = scar_pkg::MAC_W'(2);
            state_in      = ST_AVG_GL;
         end
         ST_AVG_GL: begin
            xl_in    = mac_result[scar_pkg::AP_W-1:0];
            state_in = ST_AVG_GR;
         end
         ST_AVG_GR: begin
            xr_in    = mac_result[scar_pkg::AP_W-1:0];
            k_in     = 1'b0;
            state_in = ST_A_READ;
         end
         ST_A_READ: begin
            state_in = ST_A_VL;
         end
         // Allpass: v = x + half(b), written back to the line
         ST_A_VL: begin
            bl_in         = bl_rd;
            mac_op.valid  = 1'b1;
            mac_op.mode   = scar_pkg::MODE_AP;
            mac_op.m1     = scar_pkg::M1_W'(bl_rd);
            mac_op.m2     = scar_pkg::M2_W'(1);
            mac_op.addend = (scar_pkg::MAC_W'(xl_ff) <<< 1) + scar_pkg::MAC_W'(1);
            state_in      = ST_A_VR;
         end
         ST_A_VR: begin
            br_in         = br_rd;
            mac_op.valid  = 1'b1;
            mac_op.mode   = scar_pkg::MODE_AP;
            mac_op.m1     = scar_pkg::M1_W'(br_rd);
            mac_op.m2     = scar_pkg::M2_W'(1);
            mac_op.addend = (scar_pkg::MAC_W'(xr_ff) <<< 1) + scar_pkg::MAC_W'(1);
            state_in      = ST_A_WL;
         end
         ST_A_WL: begin
            vl_in    = mac_result[scar_pkg::AP_W-1:0];
            state_in = ST_A_WR;
         end
         ST_A_WR: begin
            vr_in    = mac_result[scar_pkg::AP_W-1:0];
            state_in = ST_A_OL;
         end
         // Allpass output: b - half(v) = floor((2b - v) / 2)
         ST_A_OL: begin
            mac_op.valid  = 1'b1;
            mac_op.mode   = scar_pkg::MODE_AP;
            mac_op.m1     = scar_pkg::M1_W'(vl_ff);
            mac_op.m2     = scar_pkg::M2_W'(-1);
            mac_op.addend = scar_pkg::MAC_W'(bl_ff) <<< 1;
            state_in      = ST_A_OR;
         end
         ST_A_OR: begin
            mac_op.valid  = 1'b1;
            mac_op.mode   = scar_pkg::MODE_AP;
            mac_op.m1     = scar_pkg::M1_W'(vr_ff);
            mac_op.m2     = scar_pkg::M2_W'(-1);
            mac_op.addend = scar_pkg::MAC_W'(br_ff) <<< 1;
            state_in      = ST_A_XL;
         end
         ST_A_XL: begin
            xl_in    = mac_result[scar_pkg::AP_W-1:0];
            state_in = ST_A_XR;
         end
         ST_A_XR: begin
            xr_in = mac_result[scar_pkg::AP_W-1:0];
            if (ap_next == scar_pkg::ap_len(k_ff)) begin
               ap_pos_in[k_ff]  = '0;
               ap_full_in[k_ff] = 1'b1;
            end else begin
               ap_pos_in[k_ff] = ap_next;
            end
            if (k_ff) begin
               k_in     = 1'b0;
               state_in = ST_MIX_L1;
            end else begin
               k_in     = 1'b1;
               state_in = ST_A_READ;
            end
         end
         // Mix, first half: dry * (1 - a) + rounding, kept unshifted
         ST_MIX_L1: begin
            mac_op.valid  = 1'b1;
            mac_op.mode   = scar_pkg::MODE_RAW;
            mac_op.m1     = scar_pkg::M1_W'(dl_ff);
            mac_op.m2     = scar_pkg::M2_W'(scar_pkg::AMT_ONE) - scar_pkg::M2_W'(amount);
            mac_op.addend = scar_pkg::MAC_W'(512);
            state_in      = ST_MIX_R1;
         end
         ST_MIX_R1: begin
            mac_op.valid  = 1'b1;
            mac_op.mode   = scar_pkg::MODE_RAW;
            mac_op.m1     = scar_pkg::M1_W'(dr_ff);
            mac_op.m2     = scar_pkg::M2_W'(scar_pkg::AMT_ONE) - scar_pkg::M2_W'(amount);
            mac_op.addend = scar_pkg::MAC_W'(512);
            state_in      = ST_MIX_L2;
         end
         // Mix, second half: + wet * a, shift and clamp to the sample range
         ST_MIX_L2: begin
            mac_op.valid  = 1'b1;
            mac_op.mode   = scar_pkg::MODE_MIX;
            mac_op.m1     = scar_pkg::M1_W'(xl_ff);
            mac_op.m2     = signed'(scar_pkg::M2_W'(amount));
            mac_op.addend = mac_result;
            state_in      = ST_MIX_R2;
         end
         ST_MIX_R2: begin
            mac_op.valid  = 1'b1;
            mac_op.mode   = scar_pkg::MODE_MIX;
            mac_op.m1     = scar_pkg::M1_W'(xr_ff);
            mac_op.m2     = signed'(scar_pkg::M2_W'(amount));
            mac_op.addend = mac_result;
            state_in      = ST_MIX_GL;
         end
         ST_MIX_GL: begin
            wl_in    = mac_result[scar_pkg::SAMPLE_W-1:0];
            state_in = ST_MIX_GR;
         end
         ST_MIX_GR: begin
            wr_in    = mac_result[scar_pkg::SAMPLE_W-1:0];
            state_in = ST_DONE;
         end
         // Hand the pair to the output register once it is free
         ST_DONE: begin
            if (out_free) begin
               out_l_in     = wl_ff;
               out_r_in     = wr_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         c_ff         <= '0;
         k_ff         <= 1'b0;
         comb_pos_ff  <= '{default: '0};
         comb_full_ff <= '0;
         ap_pos_ff    <= '{default: '0};
         ap_full_ff   <= '0;
         armed_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         c_ff         <= c_in;
         k_ff         <= k_in;
         comb_pos_ff  <= comb_pos_in;
         comb_full_ff <= comb_full_in;
         ap_pos_ff    <= ap_pos_in;
         ap_full_ff   <= ap_full_in;
         armed_ff     <= armed_in;
         out_valid_ff <= out_valid_in;
      end
      dl_ff    <= dl_in;
      dr_ff    <= dr_in;
      suml_ff  <= suml_in;
      sumr_ff  <= sumr_in;
      bl_ff    <= bl_in;
      br_ff    <= br_in;
      vl_ff    <= vl_in;
      vr_ff    <= vr_in;
      xl_ff    <= xl_in;
      xr_ff    <= xr_in;
      wl_ff    <= wl_in;
      wr_ff    <= wr_in;
      out_l_ff <= out_l_in;
      out_r_ff <= out_r_in;
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.left_out  = out_l_ff;
   assign rsp_chan.right_out = out_r_ff;

endmodule
